// ===== rtl/crk_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, register codes and constants for the cure rate pipeline.
// No dependencies.
package crk_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 56;

  localparam logic [CFG_IDX_W-1:0] CFG_PREFACTOR_ONE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFACTOR_TWO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVATION_ONE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVATION_TWO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAS_CONSTANT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER_CURE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER_UNCURED  = 3'd6;

  localparam logic [31:0] GAS_RESET   = 32'd139485774;
  localparam logic [31:0] ORDER_RESET = 32'h0100_0000;

  localparam logic [47:0] FULL_SCALE     = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] LN2_Q32        = 32'hB172_17F8;
  localparam logic [31:0] LOG2E_FRAC_Q32 = 32'h7154_7653;
  localparam logic [44:0] Y_CAP          = 45'h1000_0000_0000;

  localparam int LOG_STEPS = 32;
  localparam int DIV_STEPS = 44;
  localparam int EXP_TERMS = 12;

  typedef struct packed {
    logic [31:0]        temperature;
    logic signed [31:0] cure_degree;
  } crk_in_t;

  typedef struct packed {
    logic [47:0] cure_rate;
    logic        saturated;
    logic        bad_temperature;
  } crk_out_t;

  // Reciprocal multipliers: floor(v / k) = (v * M) >> S for any 32-bit v.
  function automatic logic [32:0] recip_mult(input int k);
    logic [32:0] m;
    m = 33'h1_0000_0001;
    case (k)
      3:       m = 33'h1_5555_5556;
      5:       m = 33'h1_9999_999A;
      6:       m = 33'h1_5555_5556;
      7:       m = 33'h1_2492_4925;
      9:       m = 33'h1_C71C_71C8;
      10:      m = 33'h1_9999_999A;
      11:      m = 33'h1_745D_1746;
      12:      m = 33'h1_5555_5556;
      default: m = 33'h1_0000_0001;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] recip_shift(input int k);
    logic [5:0] s;
    s = 6'd32;
    case (k)
      1:       s = 6'd32;
      2:       s = 6'd33;
      3, 4:    s = 6'd34;
      5, 6, 7, 8: s = 6'd35;
      default: s = 6'd36;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/cure_rate_kinetics.sv =====
`timescale 1ns / 1ps
// Fully pipelined cure rate unit: log2 domain evaluation of the two rate terms.
// Depends on crk_pkg.
//
//   channel | ports                              | transfer
//   input   | in_valid, in_ready, in_data        | in_valid && in_ready
//   result  | out_valid, out_ready, out_data     | out_valid && out_ready
//   config  | cfg_we, cfg_index, cfg_wdata       | cfg_we
//
// One item enters per cycle while no result waits at the output.
// The depth is set by the 44-stage restoring divider and the two stages per
// Taylor term of the exponential.
// Synchronous reset clears all valid bits and loads the register defaults.
// While a result waits, the pipeline holds; an empty input stage still fills.
module cure_rate_kinetics (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  crk_pkg::crk_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output crk_pkg::crk_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [crk_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [crk_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int S_RT   = 1;
  localparam int S_LTOP = 2;
  localparam int S_DSET = 2;
  localparam int S_LSH  = 3;
  localparam int S_LOG  = S_LSH + crk_pkg::LOG_STEPS;
  localparam int S_SCL1 = S_LOG + 1;
  localparam int S_SCL2 = S_SCL1 + 1;
  localparam int S_DIV  = S_DSET + crk_pkg::DIV_STEPS;
  localparam int S_XP   = S_DIV + 1;
  localparam int S_X    = S_XP + 1;
  localparam int S_SUM  = S_X + 1;
  localparam int S_T    = S_SUM + 1;
  localparam int S_EXP  = S_T + 2 * crk_pkg::EXP_TERMS;
  localparam int S_SH   = S_EXP + 1;
  localparam int S_OUT  = S_SH + 1;
  localparam int NSTAGE = S_OUT + 1;

  typedef struct packed {
    logic [31:0]        temp;
    logic signed [31:0] cure;
    logic signed [33:0] uncured;
    logic               tzero;
    logic               unc_zero;
    logic               cure_zero;
    logic               apos;
    logic               bpos;
    logic [63:0]        rt;
    logic [3:0][55:0]   lv;
    logic [3:0][5:0]    lp;
    logic [3:0][31:0]   lz;
    logic [3:0][31:0]   lfrac;
    logic [3:0][39:0]   lg;
    logic [1:0][48:0]   sprod;
    logic [1:0]         sneg;
    logic [49:0]        ln_unc;
    logic [49:0]        ln_cure;
    logic [1:0][63:0]   rem;
    logic [1:0][43:0]   quo;
    logic [1:0]         dzero;
    logic [1:0]         dcap;
    logic [1:0][44:0]   y;
    logic [1:0][44:0]   xph;
    logic [1:0][31:0]   xpl;
    logic [1:0][45:0]   x;
    logic [1:0][53:0]   s;
    logic [1:0][21:0]   ip;
    logic [1:0][31:0]   t;
    logic [1:0][32:0]   term;
    logic [1:0][31:0]   tv;
    logic [1:0][33:0]   esum;
    logic [1:0][47:0]   r;
    logic [1:0]         esat;
    logic [47:0]        rate;
    logic               sat;
  } ctx_t;

  logic [55:0] prefactor_one_r, prefactor_two_r;
  logic [39:0] activation_one_r, activation_two_r;
  logic [31:0] gas_constant_r, order_cure_r, order_uncured_r;

  logic [NSTAGE-1:0] vld_r;
  ctx_t              ctx_r   [NSTAGE];
  ctx_t              ctx_nxt [NSTAGE];
  logic              adv;
  logic              ld0;

  assign adv      = !vld_r[S_OUT] || out_ready;
  assign ld0      = adv || !vld_r[0];
  assign in_ready = ld0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefactor_one_r  <= '0;
      prefactor_two_r  <= '0;
      activation_one_r <= '0;
      activation_two_r <= '0;
      gas_constant_r   <= crk_pkg::GAS_RESET;
      order_cure_r     <= crk_pkg::ORDER_RESET;
      order_uncured_r  <= crk_pkg::ORDER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crk_pkg::CFG_PREFACTOR_ONE:  prefactor_one_r  <= cfg_wdata;
        crk_pkg::CFG_PREFACTOR_TWO:  prefactor_two_r  <= cfg_wdata;
        crk_pkg::CFG_ACTIVATION_ONE: activation_one_r <= cfg_wdata[39:0];
        crk_pkg::CFG_ACTIVATION_TWO: activation_two_r <= cfg_wdata[39:0];
        crk_pkg::CFG_GAS_CONSTANT:   gas_constant_r   <= cfg_wdata[31:0];
        crk_pkg::CFG_ORDER_CURE:     order_cure_r     <= cfg_wdata[31:0];
        crk_pkg::CFG_ORDER_UNCURED:  order_uncured_r  <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ctx_nxt[0]      = '0;
    ctx_nxt[0].temp = in_data.temperature;
    ctx_nxt[0].cure = in_data.cure_degree;
  end

  for (genvar I = 1; I < NSTAGE; I++) begin : g_stage
    localparam int EK = (I - S_T + 1) / 2;

    always_comb begin
      ctx_t        p;
      ctx_t        n;
      logic [63:0] sq;
      logic [32:0] w;
      logic [63:0] pm;
      logic [64:0] pw;
      logic [7:0]  li;
      logic [39:0] src;
      logic [39:0] mag;
      logic [47:0] hi;
      logic [55:0] lo;
      logic [31:0] ord;
      logic [49:0] lnv0;
      logic [49:0] lnv1;
      logic [39:0] e;
      logic [51:0] num;
      logic [64:0] wd;
      logic        ge;
      logic [5:0]  tb;
      logic [49:0] shv;
      logic [21:0] nsh;
      logic [47:0] t1;
      logic [47:0] t2;
      logic        s1;
      logic        s2;
      logic [48:0] tot;
      p    = ctx_r[I-1];
      n    = p;
      sq   = '0;
      w    = '0;
      pm   = '0;
      pw   = '0;
      li   = '0;
      src  = '0;
      mag  = '0;
      hi   = '0;
      lo   = '0;
      ord  = '0;
      lnv0 = '0;
      lnv1 = '0;
      e    = '0;
      num  = '0;
      wd   = '0;
      ge   = 1'b0;
      tb   = '0;
      shv  = '0;
      nsh  = '0;
      t1   = '0;
      t2   = '0;
      s1   = 1'b0;
      s2   = 1'b0;
      tot  = '0;

      if (I == S_RT) begin
        n.rt        = 64'(gas_constant_r) * 64'(p.temp);
        n.uncured   = (34'sd1 <<< 30) - 34'(p.cure);
        n.tzero     = (p.temp == '0);
        n.apos      = (p.cure > 32'sd0);
        n.bpos      = (n.uncured > 34'sd0);
        n.unc_zero  = !n.bpos && (order_uncured_r != '0);
        n.cure_zero = !n.apos && (order_cure_r != '0);
        n.lv[0]     = prefactor_one_r;
        n.lv[1]     = prefactor_two_r;
        n.lv[2]     = {24'b0, p.cure};
        n.lv[3]     = {22'b0, n.uncured};
      end

      if (I == S_LTOP) begin
        for (int j = 0; j < 4; j++) begin
          tb = '0;
          for (int b = 1; b < 56; b++) begin
            if (p.lv[j][b]) begin
              tb = 6'(b);
            end
          end
          n.lp[j] = tb;
        end
      end

      if (I == S_DSET) begin
        for (int d = 0; d < 2; d++) begin
          e          = (d == 0) ? activation_one_r : activation_two_r;
          num        = {e, 12'b0};
          n.dzero[d] = (e == '0);
          n.dcap[d]  = (64'(num) >= p.rt);
          n.rem[d]   = 64'(num);
          n.quo[d]   = '0;
        end
      end

      if (I == S_LSH) begin
        for (int j = 0; j < 4; j++) begin
          if (p.lp[j] >= 6'd31) begin
            n.lz[j] = 32'(p.lv[j] >> (p.lp[j] - 6'd31));
          end else begin
            n.lz[j] = 32'(p.lv[j] << (6'd31 - p.lp[j]));
          end
          n.lfrac[j] = '0;
        end
      end

      if (I > S_LSH && I <= S_LOG) begin
        for (int j = 0; j < 4; j++) begin
          sq = 64'(p.lz[j]) * 64'(p.lz[j]);
          w  = sq[63:31];
          if (w[32]) begin
            n.lz[j]    = w[32:1];
            n.lfrac[j] = {p.lfrac[j][30:0], 1'b1};
          end else begin
            n.lz[j]    = w[31:0];
            n.lfrac[j] = {p.lfrac[j][30:0], 1'b0};
          end
        end
      end

      if (I > S_DSET && I <= S_DIV) begin
        for (int d = 0; d < 2; d++) begin
          wd = {p.rem[d], 1'b0};
          ge = (wd >= {1'b0, p.rt});
          if (ge) begin
            n.rem[d] = 64'(wd - {1'b0, p.rt});
          end else begin
            n.rem[d] = wd[63:0];
          end
          n.quo[d] = {p.quo[d][42:0], ge};
        end
      end

      if (I == S_SCL1) begin
        for (int j = 0; j < 4; j++) begin
          li      = 8'(p.lp[j]) - ((j < 2) ? 8'd16 : 8'd30);
          n.lg[j] = {li, p.lfrac[j]};
        end
        for (int k = 0; k < 2; k++) begin
          src        = (k == 0) ? n.lg[3] : n.lg[2];
          ord        = (k == 0) ? order_uncured_r : order_cure_r;
          mag        = src[39] ? 40'(-src) : src;
          hi         = 48'(ord) * 48'(mag[39:24]);
          lo         = 56'(ord) * 56'(mag[23:0]);
          n.sprod[k] = 49'(hi) + 49'(lo[55:24]);
          n.sneg[k]  = src[39];
        end
      end

      if (I == S_SCL2) begin
        lnv0      = p.sneg[0] ? 50'(-50'(p.sprod[0])) : 50'(p.sprod[0]);
        lnv1      = p.sneg[1] ? 50'(-50'(p.sprod[1])) : 50'(p.sprod[1]);
        n.ln_unc  = p.bpos ? lnv0 : '0;
        n.ln_cure = p.apos ? lnv1 : '0;
      end

      if (I == S_XP) begin
        for (int d = 0; d < 2; d++) begin
          if (p.dzero[d]) begin
            n.y[d] = '0;
          end else if (p.dcap[d]) begin
            n.y[d] = crk_pkg::Y_CAP;
          end else begin
            n.y[d] = {1'b0, p.quo[d]};
          end
          n.xph[d] = 45'(n.y[d][44:32]) * 45'(crk_pkg::LOG2E_FRAC_Q32);
          pm       = 64'(n.y[d][31:0]) * 64'(crk_pkg::LOG2E_FRAC_Q32);
          n.xpl[d] = pm[63:32];
        end
      end

      if (I == S_X) begin
        for (int d = 0; d < 2; d++) begin
          n.x[d] = 46'(p.y[d]) + 46'(p.xph[d]) + 46'(p.xpl[d]);
        end
      end

      if (I == S_SUM) begin
        n.s[0] = 54'($signed(p.lg[0])) - $signed({8'b0, p.x[0]})
               + 54'($signed(p.ln_unc));
        n.s[1] = 54'($signed(p.lg[1])) - $signed({8'b0, p.x[1]})
               + 54'($signed(p.ln_unc)) + 54'($signed(p.ln_cure));
      end

      if (I == S_T) begin
        for (int d = 0; d < 2; d++) begin
          n.ip[d]   = p.s[d][53:32];
          pm        = 64'(p.s[d][31:0]) * 64'(crk_pkg::LN2_Q32);
          n.t[d]    = pm[63:32];
          n.term[d] = 33'h1_0000_0000;
          n.esum[d] = 34'h1_0000_0000;
        end
      end

      if (I > S_T && I <= S_EXP && ((I - S_T) % 2 == 1)) begin
        for (int d = 0; d < 2; d++) begin
          pw      = 65'(p.term[d]) * 65'(p.t[d]);
          n.tv[d] = pw[63:32];
        end
      end

      if (I > S_T && I <= S_EXP && ((I - S_T) % 2 == 0)) begin
        for (int d = 0; d < 2; d++) begin
          pw        = 65'(p.tv[d]) * 65'(crk_pkg::recip_mult(EK));
          n.term[d] = 33'(pw >> crk_pkg::recip_shift(EK));
          n.esum[d] = p.esum[d] + 34'(n.term[d]);
        end
      end

      if (I == S_SH) begin
        for (int d = 0; d < 2; d++) begin
          n.esat[d] = 1'b0;
          if ($signed(p.ip[d]) >= 22'sd16) begin
            n.r[d]    = crk_pkg::FULL_SCALE;
            n.esat[d] = 1'b1;
          end else if ($signed(p.ip[d]) >= 22'sd0) begin
            shv = 50'(p.esum[d]) << p.ip[d][3:0];
            if (shv > 50'(crk_pkg::FULL_SCALE)) begin
              n.r[d]    = crk_pkg::FULL_SCALE;
              n.esat[d] = 1'b1;
            end else begin
              n.r[d] = shv[47:0];
            end
          end else begin
            nsh = 22'(-p.ip[d]);
            if (nsh >= 22'd64) begin
              n.r[d] = '0;
            end else begin
              n.r[d] = 48'(p.esum[d] >> nsh[5:0]);
            end
          end
        end
      end

      if (I == S_OUT) begin
        t1  = (prefactor_one_r == '0) ? '0 : p.r[0];
        s1  = (prefactor_one_r != '0) && p.esat[0];
        t2  = (p.cure_zero || prefactor_two_r == '0) ? '0 : p.r[1];
        s2  = !p.cure_zero && (prefactor_two_r != '0) && p.esat[1];
        tot = 49'(t1) + 49'(t2);
        if (p.tzero || p.unc_zero) begin
          n.rate = '0;
          n.sat  = 1'b0;
        end else if (s1 || s2 || tot > 49'(crk_pkg::FULL_SCALE)) begin
          n.rate = crk_pkg::FULL_SCALE;
          n.sat  = 1'b1;
        end else begin
          n.rate = tot[47:0];
          n.sat  = 1'b0;
        end
      end

      ctx_nxt[I] = n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ld0) begin
        vld_r[0] <= in_valid;
      end
      if (adv) begin
        vld_r[NSTAGE-1:1] <= vld_r[NSTAGE-2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld0) begin
      ctx_r[0] <= ctx_nxt[0];
    end
    if (adv) begin
      for (int i = 1; i < NSTAGE; i++) begin
        ctx_r[i] <= ctx_nxt[i];
      end
    end
  end

  assign out_valid                = vld_r[S_OUT];
  assign out_data.cure_rate       = ctx_r[S_OUT].rate;
  assign out_data.saturated       = ctx_r[S_OUT].sat;
  assign out_data.bad_temperature = ctx_r[S_OUT].tzero;

endmodule

// ===== rtl/crk_check.sv =====
`timescale 1ns / 1ps
// Port-level checks for cure_rate_kinetics, attached by bind.
// Depends on crk_pkg and the top level's port names.
module crk_check (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input crk_pkg::crk_out_t out_data
);

  // A waiting result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // With no result waiting, the pipeline must take input.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // A zero temperature forces a zero, unsaturated rate.
  a_bad_temp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_temperature |->
      out_data.cure_rate == '0 && !out_data.saturated)
    else $error("bad temperature with nonzero rate");

  // Saturation always reports full scale.
  a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |-> out_data.cure_rate == crk_pkg::FULL_SCALE)
    else $error("saturated rate not at full scale");

endmodule

bind cure_rate_kinetics crk_check u_crk_check (.*);
